FILE: rtl/core/rbst_pkg.sv
// Shared constants and types for the ray/box slab test.
// No dependencies; used by the channel interfaces and the top level.
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIST_WIDTH  = 48;
  localparam int NUM_AXES    = 3;

  // corner - origin grows by one bit; the product is DIFF x COORD
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
  localparam int QUOT_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int EXT_WIDTH   = (QUOT_WIDTH > DIST_WIDTH) ? QUOT_WIDTH : DIST_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [QUOT_WIDTH-1:0]  quot_t;
  typedef logic signed [EXT_WIDTH-1:0]   ext_t;
  typedef logic signed [DIST_WIDTH-1:0]  dist_t;

  // saturation limits of a distance, at the extended width
  localparam ext_t DIST_HI = {{(EXT_WIDTH-DIST_WIDTH+1){1'b0}}, {(DIST_WIDTH-1){1'b1}}};
  localparam ext_t DIST_LO = {{(EXT_WIDTH-DIST_WIDTH+1){1'b1}}, {(DIST_WIDTH-1){1'b0}}};

endpackage

FILE: rtl/core/rbst_in_if.sv
// Request channel of the slab test: box corners, ray origin, inverse direction.
// Depends on rbst_pkg for the coordinate type.
interface rbst_in_if;
  logic            valid;
  logic            ready;
  rbst_pkg::coord_t box_min_x;
  rbst_pkg::coord_t box_min_y;
  rbst_pkg::coord_t box_min_z;
  rbst_pkg::coord_t box_max_x;
  rbst_pkg::coord_t box_max_y;
  rbst_pkg::coord_t box_max_z;
  rbst_pkg::coord_t origin_x;
  rbst_pkg::coord_t origin_y;
  rbst_pkg::coord_t origin_z;
  rbst_pkg::coord_t inv_dir_x;
  rbst_pkg::coord_t inv_dir_y;
  rbst_pkg::coord_t inv_dir_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
    output ready
  );
endinterface

FILE: rtl/core/rbst_out_if.sv
// Result channel of the slab test: hit flag and entry distance.
// Depends on rbst_pkg for the distance type.
interface rbst_out_if;
  logic            valid;
  logic            ready;
  logic            hit;
  rbst_pkg::dist_t entry_distance;

  modport source (
    output valid, hit, entry_distance,
    input  ready
  );
  modport sink (
    input  valid, hit, entry_distance,
    output ready
  );
endinterface

FILE: rtl/core/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, five register stages.
// An accepted request passes stages 1 to 4, then the output register, to result valid.
// Throughput: one request per cycle unless the stages are full and the result port
// stalls; each stage holds on its own, so bubbles are squeezed out while the port stalls.
// Reset (rst_n low, synchronous) clears all stage valid bits; data regs are not reset.
// Depends on rbst_pkg, rbst_in_if and rbst_out_if.
module ray_box_slab_test (
  input  logic        clk,
  input  logic        rst_n,
  rbst_in_if.sink     in_req,
  rbst_out_if.source  out_res
);

  localparam int NA = rbst_pkg::NUM_AXES;

  // per-axis views of the request
  rbst_pkg::coord_t bmin [NA];
  rbst_pkg::coord_t bmax [NA];
  rbst_pkg::coord_t org  [NA];
  rbst_pkg::coord_t inv  [NA];

  always_comb begin
    bmin[0] = in_req.box_min_x;  bmin[1] = in_req.box_min_y;  bmin[2] = in_req.box_min_z;
    bmax[0] = in_req.box_max_x;  bmax[1] = in_req.box_max_y;  bmax[2] = in_req.box_max_z;
    org[0]  = in_req.origin_x;   org[1]  = in_req.origin_y;   org[2]  = in_req.origin_z;
    inv[0]  = in_req.inv_dir_x;  inv[1]  = in_req.inv_dir_y;  inv[2]  = in_req.inv_dir_z;
  end

  // stage registers
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  rbst_pkg::diff_t  diff_lo_r [NA];
  rbst_pkg::diff_t  diff_hi_r [NA];
  rbst_pkg::coord_t inv_r     [NA];
  rbst_pkg::prod_t  prod_lo_r [NA];
  rbst_pkg::prod_t  prod_hi_r [NA];
  rbst_pkg::dist_t  near_r    [NA];
  rbst_pkg::dist_t  far_r     [NA];
  rbst_pkg::dist_t  entry_r, exit_r;
  logic             out_hit_r;
  rbst_pkg::dist_t  out_dist_r;

  // per-stage load enables; a stage loads when empty or when its successor loads
  logic en1, en2, en3, en4, en_out;
  assign en_out = !out_valid_r || out_res.ready;
  assign en4    = !v4_r || en_out;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_req.ready = en1;

  // drop the FRAC_BITS fraction bits with a floor, then saturate to the distance range
  function automatic rbst_pkg::dist_t floor_sat(rbst_pkg::prod_t p);
    rbst_pkg::quot_t q;
    rbst_pkg::ext_t  qe;
    rbst_pkg::dist_t res;
    q  = rbst_pkg::quot_t'(p >>> rbst_pkg::FRAC_BITS);
    qe = rbst_pkg::ext_t'(q);
    if (qe > rbst_pkg::DIST_HI) begin
      res = rbst_pkg::dist_t'(rbst_pkg::DIST_HI);
    end else if (qe < rbst_pkg::DIST_LO) begin
      res = rbst_pkg::dist_t'(rbst_pkg::DIST_LO);
    end else begin
      res = rbst_pkg::dist_t'(qe);
    end
    return res;
  endfunction

  // stage 3 combinational: slab distances and per-axis near/far
  rbst_pkg::dist_t t_lo   [NA];
  rbst_pkg::dist_t t_hi   [NA];
  rbst_pkg::dist_t near_nxt [NA];
  rbst_pkg::dist_t far_nxt  [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      t_lo[a] = floor_sat(prod_lo_r[a]);
      t_hi[a] = floor_sat(prod_hi_r[a]);
      if (t_lo[a] < t_hi[a]) begin
        near_nxt[a] = t_lo[a];
        far_nxt[a]  = t_hi[a];
      end else begin
        near_nxt[a] = t_hi[a];
        far_nxt[a]  = t_lo[a];
      end
    end
  end

  // stage 4 combinational: entry is the max near, exit the min far
  rbst_pkg::dist_t entry_nxt, exit_nxt;
  always_comb begin
    entry_nxt = near_r[0];
    exit_nxt  = far_r[0];
    for (int a = 1; a < NA; a++) begin
      if (near_r[a] > entry_nxt) begin
        entry_nxt = near_r[a];
      end
      if (far_r[a] < exit_nxt) begin
        exit_nxt = far_r[a];
      end
    end
  end

  logic hit_nxt;
  assign hit_nxt = (entry_r <= exit_r) && !exit_r[rbst_pkg::DIST_WIDTH-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_req.valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int a = 0; a < NA; a++) begin
        diff_lo_r[a] <= rbst_pkg::diff_t'(bmin[a]) - rbst_pkg::diff_t'(org[a]);
        diff_hi_r[a] <= rbst_pkg::diff_t'(bmax[a]) - rbst_pkg::diff_t'(org[a]);
        inv_r[a]     <= inv[a];
      end
    end
    if (en2) begin
      for (int a = 0; a < NA; a++) begin
        prod_lo_r[a] <= rbst_pkg::prod_t'(diff_lo_r[a]) * rbst_pkg::prod_t'(inv_r[a]);
        prod_hi_r[a] <= rbst_pkg::prod_t'(diff_hi_r[a]) * rbst_pkg::prod_t'(inv_r[a]);
      end
    end
    if (en3) begin
      for (int a = 0; a < NA; a++) begin
        near_r[a] <= near_nxt[a];
        far_r[a]  <= far_nxt[a];
      end
    end
    if (en4) begin
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
    end
    if (en_out) begin
      out_hit_r  <= hit_nxt;
      out_dist_r <= hit_nxt ? entry_r : '0;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.hit            = out_hit_r;
  assign out_res.entry_distance = out_dist_r;

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_dist_r == '0)
    else $error("miss result with nonzero distance");

  // an accepted request always lands in stage 1
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> v1_r)
    else $error("accepted request lost at stage 1");

  // a full stage 4 moving on produces a valid result
  a_s4_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && en_out |=> out_valid_r)
    else $error("stage 4 item lost");

  // a held stage 3 keeps its valid bit and its axis-0 near and far contents
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en4 |=> v3_r && $stable(near_r[0]) && $stable(far_r[0]))
    else $error("stalled stage 3 changed");

endmodule
